>>> sv/bole_pkg.sv
// Package for the bounded ordered list engine: types, codes and constants.
package bole_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;

  typedef logic signed [ValueW-1:0] value_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_FIND    = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic load_key;     // take the transaction value
    logic take_prev;    // shift towards the back
    logic take_next;    // shift towards the front
    logic capture_hit;  // latch comparison against the key
  } cell_ctl_t;

endpackage

>>> sv/bole_cell.sv
// One storage cell of the list chain: value register and match flag.
module bole_cell (
  input  logic               clk_i,
  input  bole_pkg::cell_ctl_t ctl_i,
  input  bole_pkg::value_t   key_i,
  input  bole_pkg::value_t   prev_i,
  input  bole_pkg::value_t   next_i,
  output bole_pkg::value_t   value_o,
  output logic               hit_o
);
  import bole_pkg::*;

  value_t value_q, value_d;
  logic   hit_q;

  always_comb begin
    value_d = value_q;
    if (ctl_i.load_key) begin
      value_d = key_i;
    end else if (ctl_i.take_prev) begin
      value_d = prev_i;
    end else if (ctl_i.take_next) begin
      value_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (ctl_i.capture_hit) begin
      hit_q <= (value_q == key_i);
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

>>> sv/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: cell chain plus sequencer.
// Insert, remove and reverse: result strobed in the cycle after acceptance, busy stays low,
//   so one such command per cycle.
// Find: all cells compare in the acceptance cycle, then the scan walks one logical position
//   per cycle until the first hit or the end of the list, then strobes the result.
// Reset clears the entry count, the reversed view flag and the sequencer; cell contents are
//   left as they are. Results cannot be held off by the receiver.
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY = bole_pkg::DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              command_i,
  input  bole_pkg::value_t        value_i,
  input  logic [4:0]              position_i,
  output logic                    done_o,
  output logic                    accepted_o,
  output logic                    found_o,
  output logic [3:0]              found_index_o,
  output logic [4:0]              entry_total_o
);
  import bole_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned WidW = CntW + 5;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rev_q, rev_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic            done_q, done_d;
  logic            acc_q, acc_d;
  logic            fnd_q, fnd_d;
  logic [CntW-1:0] fidx_q, fidx_d;

  cmd_e            cmd;
  logic            take;
  logic [WidW-1:0] pos_w, cnt_w;
  logic [CntW-1:0] at;
  logic            ins_ok, rem_ok, rev_ok;
  logic            do_ins, do_rem_shift, do_find;
  logic [CntW-1:0] phys;
  logic            scan_end, scan_hit;
  logic [WidW-1:0] fidx_w, tot_w;

  value_t          cell_val [CAPACITY];
  logic [CAPACITY-1:0] hit;

  assign cmd  = cmd_e'(command_i);
  assign take = start_i && (state_q == ST_IDLE);

  assign pos_w  = WidW'(position_i);
  assign cnt_w  = WidW'(count_q);
  assign ins_ok = (pos_w <= cnt_w) && (cnt_w < WidW'(CAPACITY));
  assign rem_ok = (count_q != '0);
  assign rev_ok = (cnt_w >= WidW'(2));
  assign at     = rev_q ? (count_q - pos_w[CntW-1:0]) : pos_w[CntW-1:0];

  assign do_ins       = take && (cmd == CMD_INSERT) && ins_ok;
  assign do_rem_shift = take && (cmd == CMD_REMOVE) && rem_ok && !rev_q;
  assign do_find      = take && (cmd == CMD_FIND);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    value_t    prev_v, next_v;

    assign ctl.load_key    = do_ins && (at == CntW'(i));
    assign ctl.take_prev   = do_ins && (at < CntW'(i));
    assign ctl.take_next   = do_rem_shift;
    assign ctl.capture_hit = do_find;

    if (i == 0) begin : g_first
      assign prev_v = value_i;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end

    bole_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .key_i   (value_i),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .value_o (cell_val[i]),
      .hit_o   (hit[i])
    );
  end

  // scan of latched match flags in logical order
  assign phys     = rev_q ? (count_q - CntW'(1) - cursor_q) : cursor_q;
  assign scan_end = (cursor_q == count_q);
  assign scan_hit = hit[phys[IdxW-1:0]];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (do_find) state_d = ST_SCAN;
      ST_SCAN: if (scan_end || scan_hit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    rev_d    = rev_q;
    cursor_d = cursor_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    fnd_d    = fnd_q;
    fidx_d   = fidx_q;
    unique case (state_q)
      ST_IDLE: begin
        cursor_d = '0;
        if (take) begin
          fnd_d  = 1'b0;
          fidx_d = '0;
          unique case (cmd)
            CMD_INSERT: begin
              done_d = 1'b1;
              acc_d  = ins_ok;
              if (ins_ok) count_d = count_q + CntW'(1);
            end
            CMD_REMOVE: begin
              done_d = 1'b1;
              acc_d  = rem_ok;
              if (rem_ok) count_d = count_q - CntW'(1);
            end
            CMD_REVERSE: begin
              done_d = 1'b1;
              acc_d  = rev_ok;
              if (rev_ok) rev_d = !rev_q;
            end
            CMD_FIND: begin
              acc_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          done_d = 1'b1;
          fnd_d  = 1'b0;
          fidx_d = '0;
        end else if (scan_hit) begin
          done_d = 1'b1;
          fnd_d  = 1'b1;
          fidx_d = cursor_q;
        end else begin
          cursor_d = cursor_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rev_q    <= 1'b0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rev_q    <= rev_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    fnd_q  <= fnd_d;
    fidx_q <= fidx_d;
  end

  assign fidx_w = WidW'(fidx_q);
  assign tot_w  = WidW'(count_q);

  always_comb begin
    busy_o        = (state_q == ST_SCAN);
    done_o        = done_q;
    accepted_o    = acc_q;
    found_o       = fnd_q;
    found_index_o = fidx_w[3:0];
    entry_total_o = tot_w[4:0];
  end

endmodule

>>> sv/bole_checker.sv
// Port-level checker for the bounded ordered list engine, bound to the top level.
module bole_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic [1:0]       command_i,
  input bole_pkg::value_t value_i,
  input logic [4:0]       position_i,
  input logic             done_o,
  input logic             accepted_o,
  input logic             found_o,
  input logic [3:0]       found_index_o,
  input logic [4:0]       entry_total_o
);
  import bole_pkg::*;

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != CMD_FIND) |=> done_o)
    else $error("non-find transaction gave no result in the next cycle");

  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_FIND) |=> (busy_o && !done_o))
    else $error("find transaction did not enter the scan");

  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (done_o && accepted_o))
    else $error("scan ended without an accepted result");

  a_found_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> accepted_o)
    else $error("match reported on a rejected transaction");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (found_index_o == 4'd0))
    else $error("index not zero without a match");

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);
